### rtl/core/assert_macros.svh
// Assertion macros used by the reach counter top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/gdrc_pkg.sv
// Package with the field widths, request codes and default sizes of the reach counter.
package gdrc_pkg;

  localparam int TYPE_W = 2;
  localparam int IDX_W  = 13;
  localparam int VAL_W  = 14;
  localparam int CNT_W  = 11;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 8192;

  typedef logic [TYPE_W-1:0] req_type_t;

  localparam req_type_t REQ_LOAD_OFFSET = 2'd0;
  localparam req_type_t REQ_LOAD_EDGE   = 2'd1;
  localparam req_type_t REQ_RUN         = 2'd2;

endpackage

### rtl/core/graph_dfs_reach_count_top.sv
// Depth-first reachability counter over a graph held in compressed adjacency form.
//
//  Channel | Direction | Ports                                         | Moves
//  in      | input     | in_valid/in_ready, req_type, entry_index/value | one request
//  out     | output    | out_valid/out_ready, out_reached_count         | one count per run
//  cfg     | input     | cfg_valid/cfg_ready, cfg_node_count            | node count write
//
// A load request writes its entry when accepted; a request with an unused code is dropped.
// A run request first clears the visited map over the clamped node count and pushes node 0,
// then pops nodes, reads each node's row bounds and scans its edges; each edge reads its
// target, then the visited bit of a target inside the node count.
// Reset is synchronous and clears the control state only; memories keep their contents.
// A finished count waits in the output register while new requests are taken.
`include "assert_macros.svh"

module graph_dfs_reach_count_top #(
  parameter int MAX_NODES = gdrc_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = gdrc_pkg::MAX_EDGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gdrc_pkg::req_type_t       in_req_type,
  input  logic [gdrc_pkg::IDX_W-1:0] in_entry_index,
  input  logic [gdrc_pkg::VAL_W-1:0] in_entry_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gdrc_pkg::CNT_W-1:0] out_reached_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gdrc_pkg::CNT_W-1:0] cfg_node_count
);

  localparam int CNT_W_L = gdrc_pkg::CNT_W;
  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int RW  = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int EIW = $clog2(MAX_EDGES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_POP  = 4'd2;
  localparam logic [3:0] S_ID   = 4'd3;
  localparam logic [3:0] S_LO   = 4'd4;
  localparam logic [3:0] S_HI   = 4'd5;
  localparam logic [3:0] S_EDGE = 4'd6;
  localparam logic [3:0] S_TGT  = 4'd7;
  localparam logic [3:0] S_VIS  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [gdrc_pkg::VAL_W-1:0] row_mem [0:MAX_NODES];
  logic [NW-1:0]              edge_mem [0:MAX_EDGES-1];
  logic                       vis_mem [0:MAX_NODES-1];
  logic [NW-1:0]              stk_mem [0:MAX_NODES-1];

  logic [3:0]    state_r, state_nxt;
  logic [CNT_W_L-1:0] node_count_r;
  logic [CW-1:0] n_r, n_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] tally_r, tally_nxt;
  logic [NW-1:0] id_r, id_nxt;
  logic [EIW-1:0] lo_r, lo_nxt;
  logic [EIW-1:0] hi_r, hi_nxt;
  logic [EIW-1:0] e_r, e_nxt;
  logic [NW-1:0] t_r, t_nxt;
  logic          out_valid_r;
  logic [gdrc_pkg::CNT_W-1:0] out_count_r;

  logic [gdrc_pkg::VAL_W-1:0] row_rd_r;
  logic [NW-1:0]              edge_rd_r;
  logic                       vis_rd_r;
  logic [NW-1:0]              stk_rd_r;

  logic [RW-1:0] row_ra;
  logic [EW-1:0] edge_ra;
  logic [NW-1:0] vis_ra;
  logic [NW-1:0] stk_ra;
  logic          vis_we;
  logic [NW-1:0] vis_wa;
  logic          vis_wd;
  logic          stk_we;
  logic [NW-1:0] stk_wa;
  logic [NW-1:0] stk_wd;
  logic          in_acc;
  logic          out_free;
  logic          done_go;
  logic [CW-1:0] n_clamped;

  function automatic logic [EIW-1:0] clamp_offset(input logic [gdrc_pkg::VAL_W-1:0] v);
    logic [EIW-1:0] r;
    if (32'(v) > MAX_EDGES) begin
      r = EIW'(MAX_EDGES);
    end else begin
      r = EIW'(v);
    end
    return r;
  endfunction

  assign in_ready          = (state_r == S_IDLE);
  assign in_acc            = in_valid && in_ready;
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_reached_count = out_count_r;
  assign out_free          = !out_valid_r || out_ready;
  assign done_go           = (state_r == S_DONE) && out_free;

  always_comb begin
    if (node_count_r == '0) begin
      n_clamped = CW'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      n_clamped = CW'(MAX_NODES);
    end else begin
      n_clamped = CW'(node_count_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    clr_nxt   = clr_r;
    sp_nxt    = sp_r;
    tally_nxt = tally_r;
    id_nxt    = id_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    e_nxt     = e_r;
    t_nxt     = t_r;
    row_ra    = '0;
    edge_ra   = '0;
    vis_ra    = '0;
    stk_ra    = '0;
    vis_we    = 1'b0;
    vis_wa    = '0;
    vis_wd    = 1'b0;
    stk_we    = 1'b0;
    stk_wa    = '0;
    stk_wd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_req_type == gdrc_pkg::REQ_RUN) begin
          n_nxt     = n_clamped;
          clr_nxt   = '0;
          sp_nxt    = CW'(1);
          tally_nxt = '0;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        vis_we = 1'b1;
        vis_wa = clr_r;
        vis_wd = (clr_r == '0);
        if (clr_r == '0) begin
          stk_we = 1'b1;
        end
        if (CW'(clr_r) == n_r - CW'(1)) begin
          state_nxt = S_POP;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          sp_nxt    = sp_r - CW'(1);
          stk_ra    = NW'(sp_r - CW'(1));
          tally_nxt = tally_r + CW'(1);
          state_nxt = S_ID;
        end
      end
      S_ID: begin
        id_nxt    = stk_rd_r;
        row_ra    = RW'(stk_rd_r);
        state_nxt = S_LO;
      end
      S_LO: begin
        lo_nxt    = clamp_offset(row_rd_r);
        row_ra    = RW'(id_r) + RW'(1);
        state_nxt = S_HI;
      end
      S_HI: begin
        hi_nxt    = clamp_offset(row_rd_r);
        e_nxt     = lo_r;
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        if (e_r < hi_r) begin
          edge_ra   = EW'(e_r);
          e_nxt     = e_r + EIW'(1);
          state_nxt = S_TGT;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_TGT: begin
        if (CW'(edge_rd_r) < n_r) begin
          vis_ra    = edge_rd_r;
          t_nxt     = edge_rd_r;
          state_nxt = S_VIS;
        end else begin
          state_nxt = S_EDGE;
        end
      end
      S_VIS: begin
        if (!vis_rd_r) begin
          vis_we = 1'b1;
          vis_wa = t_r;
          vis_wd = 1'b1;
          if (32'(sp_r) < MAX_NODES) begin
            stk_we = 1'b1;
            stk_wa = NW'(sp_r);
            stk_wd = t_r;
            sp_nxt = sp_r + CW'(1);
          end
        end
        state_nxt = S_EDGE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= CNT_W_L'(1);
      sp_r         <= '0;
      tally_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      tally_r <= tally_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    clr_r <= clr_nxt;
    id_r  <= id_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    e_r   <= e_nxt;
    t_r   <= t_nxt;
    if (done_go) begin
      out_count_r <= CNT_W_L'(tally_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == gdrc_pkg::REQ_LOAD_OFFSET
        && 32'(in_entry_index) <= MAX_NODES) begin
      row_mem[RW'(in_entry_index)] <= in_entry_value;
    end
    row_rd_r <= row_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == gdrc_pkg::REQ_LOAD_EDGE && 32'(in_entry_index) < MAX_EDGES
        && 32'(in_entry_value) < MAX_NODES) begin
      edge_mem[EW'(in_entry_index)] <= NW'(in_entry_value);
    end
    edge_rd_r <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd_r <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stk_mem[stk_ra];
  end

  `ASSERT_ALWAYS(a_stack_bound, clk, rst_n, (state_r == S_IDLE) || (sp_r <= n_r))
  `ASSERT_ALWAYS(a_tally_bound, clk, rst_n, (state_r == S_IDLE) || (tally_r <= n_r))
  `ASSERT_NEXT(a_done_result, clk, rst_n, done_go, out_valid_r && (state_r == S_IDLE))

endmodule
